[src/oal_pkg.sv]
// Shared types, codes and constants of the ordered array list.
package oal_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int GROUP        = 8;
  localparam int POS_W        = 6;
  localparam int CNT_W        = 7;
  localparam int IN_KEY_W     = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECT   = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [POS_W-1:0]    position;
    logic [IN_KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] found_position;
    logic [CNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic             insert_en;
    logic             remove_en;
    logic             cmp_en;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

[src/oal_cell.sv]
// One list slot: holds a key, shifts with its neighbors, compares against a search key.
module oal_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = oal_pkg::KEY_BITS_DEF,
  parameter int CW       = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  oal_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0] key,
  input  logic [CW-1:0]       count,
  input  logic [KEY_BITS-1:0] left,
  input  logic [KEY_BITS-1:0] right,
  output logic [KEY_BITS-1:0] entry,
  output logic                match
);

  localparam int PW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;
  localparam logic [PW-1:0] IDX_P = PW'(IDX);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [KEY_BITS-1:0] entry_r, entry_nxt;
  logic                match_r, match_nxt;
  logic [PW-1:0]       pos_ext;

  assign pos_ext = PW'(ctl.pos);

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (ctl.insert_en) begin
      if (IDX_P == pos_ext) begin
        entry_nxt = key;
      end else if (IDX_P > pos_ext) begin
        entry_nxt = left;
      end
    end
    if (ctl.remove_en && (IDX_P >= pos_ext)) begin
      entry_nxt = right;
    end
    if (ctl.cmp_en) begin
      match_nxt = (entry_r == key) && (IDX_C < count);
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

[src/oal_scan.sv]
// Group scanner: picks the first set match bit inside one group of eight cells.
module oal_scan #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
  parameter int GW       = 3
) (
  input  logic [CAPACITY-1:0]        match,
  input  logic [GW-1:0]              grp,
  output logic                       hit,
  output logic [oal_pkg::POS_W-1:0]  found_pos
);

  localparam int G    = oal_pkg::GROUP;
  localparam int PADW = G * (1 << GW);
  localparam int FW   = GW + 3;

  logic [PADW-1:0] match_pad;
  logic [G-1:0]    sel;
  logic [2:0]      pr;
  logic [FW-1:0]   full_idx;

  assign match_pad = PADW'(match);
  assign sel       = match_pad[grp*G +: G];
  assign hit       = |sel;

  always_comb begin
    pr = 3'd0;
    for (int i = G - 1; i >= 0; i--) begin
      if (sel[i]) begin
        pr = 3'(i);
      end
    end
  end

  assign full_idx = {grp, pr};

  generate
    if (FW >= oal_pkg::POS_W) begin : g_trunc
      assign found_pos = full_idx[oal_pkg::POS_W-1:0];
    end else begin : g_ext
      assign found_pos = {{(oal_pkg::POS_W-FW){1'b0}}, full_idx};
    end
  endgenerate

endmodule

[src/ordered_array_list.sv]
// Ordered array list: row of key cells with positional insert/remove and first-match find.
// Insert, remove and rejected items: result strobe in the cycle after accept, busy stays low.
// Find: match bits latch at accept, then a scanner checks eight cells a cycle; the strobe is
// registered from the first group with a hit, or from the last group, busy high meanwhile.
// Reset clears the count and control; stored keys are undefined until written.
// Results are strobed for one cycle; the receiver cannot stall.
module ordered_array_list #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = oal_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  oal_pkg::in_t  in_data,
  output logic          out_valid,
  output oal_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + oal_pkg::GROUP - 1) / oal_pkg::GROUP;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;
  localparam logic [CW-1:0] FULL_C   = CW'(CAPACITY);
  localparam logic [GW-1:0] LAST_GRP = GW'(NG - 1);

  oal_pkg::fsm_t       state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [GW-1:0]       grp_r, grp_nxt;
  logic                out_valid_r, out_valid_nxt;
  oal_pkg::out_t       out_data_r, out_data_nxt;
  oal_pkg::cell_ctl_t  ctl;
  logic [KEY_BITS-1:0] key_k;
  logic [KEY_BITS-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic                accept;
  logic [PW-1:0]       pos_ext, count_ext;
  logic                hit;
  logic [oal_pkg::POS_W-1:0] scan_pos;

  generate
    if (KEY_BITS <= oal_pkg::IN_KEY_W) begin : g_key_trunc
      assign key_k = in_data.key[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign key_k = {{(KEY_BITS-oal_pkg::IN_KEY_W){1'b0}}, in_data.key};
    end
  endgenerate

  assign accept    = start && (state_r == oal_pkg::S_IDLE);
  assign pos_ext   = PW'(in_data.position);
  assign count_ext = PW'(count_r);

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = key_k;
      end else begin : g_mid_l
        assign left_w = ent[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = ent[i];
      end else begin : g_mid_r
        assign right_w = ent[i+1];
      end
      oal_cell #(
        .IDX      (i),
        .KEY_BITS (KEY_BITS),
        .CW       (CW)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .key   (key_k),
        .count (count_r),
        .left  (left_w),
        .right (right_w),
        .entry (ent[i]),
        .match (match[i])
      );
    end
  endgenerate

  oal_scan #(
    .CAPACITY (CAPACITY),
    .GW       (GW)
  ) u_scan (
    .match     (match),
    .grp       (grp_r),
    .hit       (hit),
    .found_pos (scan_pos)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    grp_nxt       = grp_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.pos       = in_data.position;
    case (state_r)
      oal_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = oal_pkg::ST_REJECT;
          out_data_nxt.found_position = '0;
          if (in_data.mode == oal_pkg::MODE_INSERT) begin
            if ((count_r != FULL_C) && (pos_ext <= count_ext)) begin
              ctl.insert_en       = 1'b1;
              count_nxt           = count_r + 1'b1;
              out_data_nxt.status = oal_pkg::ST_DONE;
            end
          end else if (in_data.mode == oal_pkg::MODE_REMOVE) begin
            if (pos_ext < count_ext) begin
              ctl.remove_en       = 1'b1;
              count_nxt           = count_r - 1'b1;
              out_data_nxt.status = oal_pkg::ST_DONE;
            end
          end else if (in_data.mode == oal_pkg::MODE_FIND) begin
            ctl.cmp_en    = 1'b1;
            out_valid_nxt = 1'b0;
            grp_nxt       = '0;
            state_nxt     = oal_pkg::S_SCAN;
          end
          out_data_nxt.entry_count = oal_pkg::CNT_W'(count_nxt);
        end
      end
      oal_pkg::S_SCAN: begin
        if (hit || (grp_r == LAST_GRP)) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.entry_count = oal_pkg::CNT_W'(count_r);
          if (hit) begin
            out_data_nxt.status         = oal_pkg::ST_DONE;
            out_data_nxt.found_position = scan_pos;
          end else begin
            out_data_nxt.status         = oal_pkg::ST_NOTFOUND;
            out_data_nxt.found_position = '0;
          end
          state_nxt = oal_pkg::S_IDLE;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = oal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oal_pkg::S_IDLE;
      count_r     <= '0;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != oal_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/oal_result_monitor.sv]
`timescale 1ns / 100ps
// Result monitor: predicts each accepted list command and compares the strobed result.
module oal_result_monitor
  import oal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  output int   fail_count,
  output int   awaited
);

  logic [KEY_BITS-1:0] shadow_keys [CAPACITY];
  int unsigned         shadow_count;
  out_t                awaited_results [$];
  int                  mismatch_total;

  function automatic out_t apply_command(in_t cmd);
    out_t                res;
    logic [KEY_BITS-1:0] k;
    int                  i;
    int                  pos;
    k = KEY_BITS'(cmd.key);
    pos = int'(cmd.position);
    res.status = ST_REJECT;
    res.found_position = '0;
    case (cmd.mode)
      MODE_INSERT: begin
        if (shadow_count < CAPACITY && pos <= shadow_count) begin
          for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[pos] = k;
          shadow_count++;
          res.status = ST_DONE;
        end
      end
      MODE_REMOVE: begin
        if (pos < shadow_count) begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          res.status = ST_DONE;
        end
      end
      MODE_FIND: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (res.status == ST_NOTFOUND && shadow_keys[i] == k) begin
            res.status = ST_DONE;
            res.found_position = POS_W'(i);
          end
        end
      end
      default: res.status = ST_REJECT;
    endcase
    res.entry_count = CNT_W'(shadow_count);
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: unexpected result beat status %0d pos %0d count %0d", $time,
                     out_data.status, out_data.found_position, out_data.entry_count);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.found_position !== want.found_position ||
              out_data.entry_count !== want.entry_count) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t: mismatch expected status %0d pos %0d count %0d, got %0d %0d %0d",
                       $time, want.status, want.found_position, want.entry_count,
                       out_data.status, out_data.found_position, out_data.entry_count);
          end
        end
      end
      if (start && !busy) awaited_results.push_back(apply_command(in_data));
    end
    fail_count <= mismatch_total;
    awaited <= awaited_results.size();
  end

endmodule

[sim/ordered_array_list_tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives command beats into the ordered array list and reports the verdict.
module ordered_array_list_tb;
  import oal_pkg::*;

  typedef enum int {
    LOAD_FILL  = 0,
    LOAD_MIXED = 1,
    LOAD_DRAIN = 2
  } load_bias_t;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         ITEM_TOTAL   = 1100;
  localparam int         SEGMENT_LEN  = 110;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 20;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  in_t                 in_data   = '0;
  logic                busy;
  logic                out_valid;
  out_t                out_data;
  int                  fail_count;
  int                  awaited;
  int                  cycles;
  logic [CNT_W-1:0]    seen_count = '0;
  logic [IN_KEY_W-1:0] key_pool [16];

  ordered_array_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  oal_result_monitor MON (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid) seen_count <= out_data.entry_count;
  end

  function automatic in_t make_beat(logic [1:0] m, int p, logic [IN_KEY_W-1:0] k);
    in_t beat;
    beat.mode = m;
    beat.position = POS_W'(p);
    beat.key = k;
    return beat;
  endfunction

  function automatic in_t random_beat(load_bias_t bias);
    int         roll;
    int         cnt;
    int         pos;
    int         ins_lim;
    int         rem_lim;
    logic [1:0] op;
    logic [IN_KEY_W-1:0] k;
    cnt = int'(seen_count);
    case (bias)
      LOAD_FILL: begin
        ins_lim = 75;
        rem_lim = 80;
      end
      LOAD_DRAIN: begin
        ins_lim = 5;
        rem_lim = 80;
      end
      default: begin
        ins_lim = 35;
        rem_lim = 70;
      end
    endcase
    roll = $urandom_range(99, 0);
    if (roll < ins_lim) op = MODE_INSERT;
    else if (roll < rem_lim) op = MODE_REMOVE;
    else if (roll < 96) op = MODE_FIND;
    else op = MODE_UNUSED;
    roll = $urandom_range(99, 0);
    if (roll < 65) k = key_pool[$urandom_range(15, 0)];
    else if (roll < 72) k = '0;
    else if (roll < 79) k = '1;
    else k = $urandom();
    roll = $urandom_range(99, 0);
    case (op)
      MODE_INSERT: begin
        if (roll < 70) pos = $urandom_range(cnt, 0);
        else if (roll < 85) pos = cnt;
        else pos = $urandom_range(63, 0);
      end
      MODE_REMOVE: begin
        if (roll < 75) pos = (cnt == 0) ? 0 : $urandom_range(cnt - 1, 0);
        else if (roll < 82) pos = cnt;
        else pos = $urandom_range(63, 0);
      end
      default: pos = $urandom_range(63, 0);
    endcase
    if (pos > 63) pos = 63;
    return make_beat(op, pos, k);
  endfunction

  task automatic send_beat(in_t beat);
    start <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int gap_pct);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_t        directed_beats [$];
    int         n;
    int         gap_pct;
    load_bias_t bias;
    for (n = 0; n < 16; n++) key_pool[n] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    directed_beats.push_back(make_beat(MODE_FIND, 0, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_REMOVE, 0, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_REMOVE, 63, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_INSERT, 1, 32'h0000_0001));
    directed_beats.push_back(make_beat(MODE_UNUSED, 63, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_INSERT, 0, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_INSERT, 1, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_INSERT, 0, 32'hA5A5_A5A5));
    directed_beats.push_back(make_beat(MODE_INSERT, 2, 32'h5A5A_5A5A));
    directed_beats.push_back(make_beat(MODE_INSERT, 5, 32'h0000_0001));
    directed_beats.push_back(make_beat(MODE_FIND, 63, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_FIND, 0, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_INSERT, 4, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_FIND, 0, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_FIND, 0, 32'h1234_5678));
    directed_beats.push_back(make_beat(MODE_REMOVE, 5, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_REMOVE, 0, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_REMOVE, 1, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_FIND, 0, 32'hFFFF_FFFF));
    directed_beats.push_back(make_beat(MODE_INSERT, 63, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_REMOVE, 63, 32'h0000_0000));
    directed_beats.push_back(make_beat(MODE_UNUSED, 0, 32'h0000_0000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < directed_beats.size(); n++) begin
      idle_gap(6);
      send_beat(directed_beats[n]);
    end
    hold_until_drained();

    for (n = 0; n < ITEM_TOTAL; n++) begin
      if (n == ITEM_TOTAL / 3 || n == 2 * ITEM_TOTAL / 3) hold_until_drained();
      if (n < ITEM_TOTAL / 3) gap_pct = 6;
      else if (n < 2 * ITEM_TOTAL / 3) gap_pct = 85;
      else gap_pct = 0;
      bias = load_bias_t'((n / SEGMENT_LEN) % 3);
      idle_gap(gap_pct);
      send_beat(random_beat(bias));
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
